[design/ws2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws2_pkg
// Shared types, register indexes and reset values for the LED line driver.
// ----------------------------------------------------------------------------
package ws2_pkg;

   localparam int TIME_W  = 10;
   localparam int RESET_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TIME_W-1:0]  ZERO_HIGH_RST = 10'd14;
   localparam logic [TIME_W-1:0]  ZERO_LOW_RST  = 10'd72;
   localparam logic [TIME_W-1:0]  ONE_HIGH_RST  = 10'd50;
   localparam logic [TIME_W-1:0]  ONE_LOW_RST   = 10'd30;
   localparam logic [RESET_W-1:0] RESET_TICKS_RST = 16'd7200;

   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_TICKS = 3'd4;

   typedef struct packed {
      logic       action;
      logic [7:0] color_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic pin_level;
      logic slot_free;
      logic frame_done;
      logic underrun;
   } rsp_type;

   // classified tick as it sits in the queue
   typedef struct packed {
      logic       offer;
      logic [7:0] color_byte;
      logic       frame_last;
   } tick_type;

   typedef struct packed {
      logic     valid;
      tick_type tick;
   } queue_head_type;

   function automatic logic [RESET_W-1:0] at_least_one(input logic [RESET_W-1:0] v);
      return (v == '0) ? RESET_W'(1) : v;
   endfunction

endpackage

[design/ws2_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws2_front
// Accepts requests, classifies them and queues them for the line engine.
// ----------------------------------------------------------------------------
module ws2_front import ws2_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   output queue_head_type head,
   input  logic           pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tick_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   tick_type           tick;

   assign req_stall = (count_ff == CNT_W'(DEPTH));
   assign push      = req_valid && !req_stall;

   assign tick.offer      = req_data.action;
   assign tick.color_byte = req_data.color_byte;
   assign tick.frame_last = req_data.frame_last;

   assign head.valid = (count_ff != '0);
   assign head.tick  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= tick;
      end
   end

endmodule

[design/ws2_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws2_back
// Line engine: holding slot, bit shifter, timing counter and result register.
// ----------------------------------------------------------------------------
module ws2_back import ws2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_head_type        head,
   output logic                  pop,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW, PH_RESET} phase_type;

   logic [TIME_W-1:0]  zero_high_ff, zero_low_ff, one_high_ff, one_low_ff;
   logic [RESET_W-1:0] reset_ticks_ff;

   phase_type          phase_ff, phase_in;
   logic [RESET_W-1:0] count_ff, count_in;
   logic [7:0]         shift_ff, shift_in;
   logic [2:0]         bits_left_ff, bits_left_in;
   logic               shift_last_ff, shift_last_in;
   logic [7:0]         hold_byte_ff, hold_byte_in;
   logic               hold_valid_ff, hold_valid_in;
   logic               hold_last_ff, hold_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               pin, done, under;

   assign csr_ready = 1'b1;
   assign pop       = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   function automatic logic [RESET_W-1:0] high_time(input logic b,
                                                    input logic [TIME_W-1:0] t1,
                                                    input logic [TIME_W-1:0] t0);
      return at_least_one(RESET_W'(b ? t1 : t0));
   endfunction

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      shift_in      = shift_ff;
      bits_left_in  = bits_left_ff;
      shift_last_in = shift_last_ff;
      hold_byte_in  = hold_byte_ff;
      hold_valid_in = hold_valid_ff;
      hold_last_in  = hold_last_ff;
      pin   = 1'b0;
      done  = 1'b0;
      under = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (pop) begin
         // slot takes the byte before the shifter runs
         if (head.tick.offer && !hold_valid_ff) begin
            hold_byte_in  = head.tick.color_byte;
            hold_last_in  = head.tick.frame_last;
            hold_valid_in = 1'b1;
         end

         if (phase_in == PH_IDLE && hold_valid_in) begin
            shift_in      = hold_byte_in;
            shift_last_in = hold_last_in;
            bits_left_in  = 3'd7;
            hold_valid_in = 1'b0;
            phase_in      = PH_HIGH;
            count_in      = high_time(hold_byte_in[7], one_high_ff, zero_high_ff);
         end

         unique case (phase_in)
            PH_HIGH: begin
               pin = 1'b1;
               if (count_in <= RESET_W'(1)) begin
                  phase_in = PH_LOW;
                  count_in = high_time(shift_in[7], one_low_ff, zero_low_ff);
               end else begin
                  count_in = count_in - RESET_W'(1);
               end
            end
            PH_LOW: begin
               if (count_in <= RESET_W'(1)) begin
                  count_in = '0;
                  if (bits_left_in != 3'd0) begin
                     bits_left_in = bits_left_in - 3'd1;
                     shift_in     = {shift_in[6:0], 1'b0};
                     phase_in     = PH_HIGH;
                     count_in     = high_time(shift_in[7], one_high_ff, zero_high_ff);
                  end else if (shift_last_in) begin
                     phase_in = PH_RESET;
                     count_in = at_least_one(reset_ticks_ff);
                  end else if (hold_valid_in) begin
                     shift_in      = hold_byte_in;
                     shift_last_in = hold_last_in;
                     bits_left_in  = 3'd7;
                     hold_valid_in = 1'b0;
                     phase_in      = PH_HIGH;
                     count_in      = high_time(hold_byte_in[7], one_high_ff, zero_high_ff);
                  end else begin
                     under    = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end else begin
                  count_in = count_in - RESET_W'(1);
               end
            end
            PH_RESET: begin
               if (count_in <= RESET_W'(1)) begin
                  count_in = '0;
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  count_in = count_in - RESET_W'(1);
               end
            end
            default: begin
            end
         endcase

         rsp_valid_in          = 1'b1;
         rsp_data_in.pin_level = pin;
         rsp_data_in.slot_free = !hold_valid_in;
         rsp_data_in.frame_done = done;
         rsp_data_in.underrun  = under;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= '0;
         shift_ff      <= '0;
         bits_left_ff  <= '0;
         shift_last_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         hold_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         shift_ff      <= shift_in;
         bits_left_ff  <= bits_left_in;
         shift_last_ff <= shift_last_in;
         hold_valid_ff <= hold_valid_in;
         hold_last_ff  <= hold_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff   <= ZERO_HIGH_RST;
         zero_low_ff    <= ZERO_LOW_RST;
         one_high_ff    <= ONE_HIGH_RST;
         one_low_ff     <= ONE_LOW_RST;
         reset_ticks_ff <= RESET_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ZERO_HIGH:   zero_high_ff   <= csr_data[TIME_W-1:0];
            CSR_ZERO_LOW:    zero_low_ff    <= csr_data[TIME_W-1:0];
            CSR_ONE_HIGH:    one_high_ff    <= csr_data[TIME_W-1:0];
            CSR_ONE_LOW:     one_low_ff     <= csr_data[TIME_W-1:0];
            CSR_RESET_TICKS: reset_ticks_ff <= csr_data[RESET_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

[design/ws2812_waveform_generator.sv]
`timescale 1ns / 1ps
// A request goes into the queue, then is popped into the result register.
// Throughput: one request and one retired tick per cycle while rsp_stall is low.
// req_stall rises only when the two-entry queue is full (result side stalled).
// Reset (synchronous, active high) empties the queue, idles the line engine and
// restores the timing registers to their defaults.
// ----------------------------------------------------------------------------
// ws2812_waveform_generator
// Single-wire LED line driver: queued tick requests drive a bit-timing engine.
// ----------------------------------------------------------------------------
module ws2812_waveform_generator import ws2_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   queue_head_type head;
   logic           pop;

   ws2_front #(
      .DEPTH(DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   ws2_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[design/ws2_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws2_checker
// Port-level checks on the LED line driver, bound to the top level.
// ----------------------------------------------------------------------------
module ws2_checker import ws2_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_data,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // frame end happens in the reset low period
   a_done_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> !rsp_data.pin_level)
      else $error("frame_done with line high");

   a_under_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.underrun |-> !rsp_data.pin_level && !rsp_data.frame_done)
      else $error("underrun with line high or frame_done");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ws2812_waveform_generator ws2_checker u_ws2_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED line driver. Random and directed tick
// requests go in, and a cycle-level line model predicts each tick's result.
// Several timing settings are loaded between traffic bursts, and both sides
// insert random idle cycles. Once, the result side is held off long enough to
// back-pressure the request side.
// ----------------------------------------------------------------------------
module tb_top;
   import ws2_pkg::*;

   localparam int QUIET_LIMIT = 1000;   // cycles with no handshake at all
   localparam int MAX_PRINTS  = 40;

   typedef enum logic [1:0] {
      LINE_IDLE,
      LINE_HIGH,
      LINE_LOW,
      LINE_GAP
   } line_phase_type;

   // Line model plus the queue of per-tick results it has predicted.
   class line_scoreboard_type;
      logic [TIME_W-1:0]  zero_high, zero_low, one_high, one_low;
      logic [RESET_W-1:0] frame_gap;
      line_phase_type     phase;
      logic [15:0]        countdown;
      logic [7:0]         shifter;
      logic [2:0]         bits_left;
      bit                 shift_last;
      logic [7:0]         slot_byte;
      bit                 slot_full;
      bit                 slot_last;
      rsp_type            expected_q[$];
      int                 errors;
      int                 checked;

      function new();
         zero_high  = ZERO_HIGH_RST;
         zero_low   = ZERO_LOW_RST;
         one_high   = ONE_HIGH_RST;
         one_low    = ONE_LOW_RST;
         frame_gap  = RESET_TICKS_RST;
         phase      = LINE_IDLE;
         countdown  = '0;
         shifter    = '0;
         bits_left  = '0;
         shift_last = 1'b0;
         slot_byte  = '0;
         slot_full  = 1'b0;
         slot_last  = 1'b0;
         errors     = 0;
         checked    = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_ZERO_HIGH:   zero_high = val[TIME_W-1:0];
            CSR_ZERO_LOW:    zero_low  = val[TIME_W-1:0];
            CSR_ONE_HIGH:    one_high  = val[TIME_W-1:0];
            CSR_ONE_LOW:     one_low   = val[TIME_W-1:0];
            CSR_RESET_TICKS: frame_gap = val;
            default: ;
         endcase
      endfunction

      // a zero count still lasts one tick
      function logic [15:0] ticks_of(logic [15:0] v);
         return (v == '0) ? 16'd1 : v;
      endfunction

      function void begin_high();
         phase     = LINE_HIGH;
         countdown = ticks_of(shifter[7] ? 16'(one_high) : 16'(zero_high));
      endfunction

      function void take_slot();
         shifter    = slot_byte;
         shift_last = slot_last;
         bits_left  = 3'd7;
         slot_full  = 1'b0;
         begin_high();
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         if (r.action && !slot_full) begin
            slot_byte = r.color_byte;
            slot_last = r.frame_last;
            slot_full = 1'b1;
         end
         if (phase == LINE_IDLE && slot_full)
            take_slot();
         case (phase)
            LINE_HIGH: begin
               e.pin_level = 1'b1;
               if (countdown <= 1) begin
                  phase     = LINE_LOW;
                  countdown = ticks_of(shifter[7] ? 16'(one_low) : 16'(zero_low));
               end else begin
                  countdown--;
               end
            end
            LINE_LOW: begin
               if (countdown <= 1) begin
                  countdown = '0;
                  if (bits_left != 0) begin
                     bits_left--;
                     shifter = shifter << 1;
                     begin_high();
                  end else if (shift_last) begin
                     phase     = LINE_GAP;
                     countdown = ticks_of(frame_gap);
                  end else if (slot_full) begin
                     take_slot();
                  end else begin
                     e.underrun = 1'b1;
                     phase      = LINE_IDLE;
                  end
               end else begin
                  countdown--;
               end
            end
            LINE_GAP: begin
               if (countdown <= 1) begin
                  countdown    = '0;
                  e.frame_done = 1'b1;
                  phase        = LINE_IDLE;
               end else begin
                  countdown--;
               end
            end
            default: ;
         endcase
         e.slot_free = !slot_full;
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTS)
            $display("%0t mismatch: %s", $realtime, msg);
      endtask

      task compare_field(string name, logic got, logic want);
         if (got !== want)
            report($sformatf("tick %0d %s got %b want %b", checked, name, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result %b with no request outstanding", got));
            return;
         end
         want = expected_q.pop_front();
         compare_field("pin_level", got.pin_level, want.pin_level);
         compare_field("slot_free", got.slot_free, want.slot_free);
         compare_field("frame_done", got.frame_done, want.frame_done);
         compare_field("underrun", got.underrun, want.underrun);
         checked++;
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   line_scoreboard_type ledger;
   int sent_ticks;
   int rsp_seen;
   int quiet_cycles;
   int frame_bytes_left;
   int late_ticks;
   bit held_off;

   ws2812_waveform_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly well-formed frames: a byte is offered when the slot is free, with
   // now and then a late byte (underrun) or a byte thrown at a full slot.
   function automatic req_type next_tick();
      req_type t;
      t.action     = 1'b0;
      t.color_byte = 8'($urandom);
      t.frame_last = 1'($urandom);
      if (late_ticks != 0) begin
         late_ticks--;
      end else if (!ledger.slot_full) begin
         if ($urandom_range(0, 99) < 3) begin
            late_ticks = $urandom_range(1, 60);
         end else if ($urandom_range(0, 99) < 75) begin
            if (frame_bytes_left == 0)
               frame_bytes_left = $urandom_range(1, 6);
            frame_bytes_left--;
            t.action = 1'b1;
            if ($urandom_range(0, 99) >= 5)
               t.frame_last = (frame_bytes_left == 0);
         end
      end else if ($urandom_range(0, 99) < 10) begin
         t.action = 1'b1;   // slot busy, byte gets dropped
      end
      return t;
   endfunction

   task automatic send_tick(input req_type t);
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_ticks++;
      ledger.note_request(t);
   endtask

   task automatic sender_pause();
      if (sent_ticks >= 700 && sent_ticks < 900)
         return;
      while ($urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic run_ticks(input int count);
      repeat (count) begin
         sender_pause();
         send_tick(next_tick());
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ledger.set_register(idx, val);
   endtask

   // drain, let the pipe settle, then load a new timing set
   task automatic program_timing(input logic [15:0] zh, input logic [15:0] zl,
                                 input logic [15:0] oh, input logic [15:0] ol,
                                 input logic [15:0] gap);
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_csr(CSR_ZERO_HIGH, zh);
      write_csr(CSR_ZERO_LOW, zl);
      write_csr(CSR_ONE_HIGH, oh);
      write_csr(CSR_ONE_LOW, ol);
      write_csr(CSR_RESET_TICKS, gap);
      csr_valid <= 1'b0;
   endtask

   // result side: random stall, one long hold-off, one quiet stretch
   initial begin
      rsp_stall <= 1'b0;
      rsp_seen  = 0;
      held_off  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            ledger.check_result(rsp_data);
            rsp_seen++;
         end
         if (rsp_seen == 300 && !held_off) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
         end
         if (rsp_seen >= 700 && rsp_seen < 900)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(0, 99) < 14);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_type t;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      ledger           = new();
      sent_ticks       = 0;
      quiet_cycles     = 0;
      frame_bytes_left = 0;
      late_ticks       = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_ticks(50);   // power-on timing

      program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      // directed: plain tick, byte while idle, byte into the slot, byte dropped
      // on a full slot, then plain ticks with extreme payloads
      for (int i = 0; i < 24; i++) begin
         t.action     = (i >= 1 && i <= 3);
         t.color_byte = (i == 1 || i[0]) ? 8'hFF : (i == 3 ? 8'hA5 : 8'h00);
         t.frame_last = (i == 0 || i == 2 || (i > 3 && !i[0]));
         sender_pause();
         send_tick(t);
      end
      run_ticks(250);

      program_timing(16'd2, 16'd3, 16'd3, 16'd2, 16'd5);
      run_ticks(300);
      program_timing(16'd1, 16'd6, 16'd5, 16'd1, 16'd3);
      run_ticks(300);
      program_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                     16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                     16'($urandom_range(1, 40)));
      run_ticks(300);
      program_timing(16'd4, 16'd4, 16'd4, 16'd4, 16'd30);
      run_ticks(280);
      program_timing(16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'd65535);
      run_ticks(40);

      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (ledger.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
design/ws2_pkg.sv
design/ws2_front.sv
design/ws2_back.sv
design/ws2812_waveform_generator.sv
design/ws2_checker.sv
dv/tb_top.sv
